// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/zbv_pkg.sv =====
// ---------------------------------------------------------------------------
// zbv_pkg
// Types, request codes and constants of the zone box visibility table.
// ---------------------------------------------------------------------------
package zbv_pkg;

    localparam int MAX_BOXES_DEF = 128;

    // Request codes carried on the slave tuser
    localparam logic [2:0] REQ_CLEAR    = 3'd0;
    localparam logic [2:0] REQ_ADD      = 3'd1;
    localparam logic [2:0] REQ_UPDATE   = 3'd2;
    localparam logic [2:0] REQ_CLASSIFY = 3'd3;
    localparam logic [2:0] REQ_QUERY    = 3'd4;

    // Register indexes on the configuration port
    localparam logic REG_DOOR_REACH = 1'b0;
    localparam logic REG_OBJ_MARGIN = 1'b1;

    localparam logic [11:0] DOOR_REACH_RST = 12'd500;
    localparam logic [11:0] OBJ_MARGIN_RST = 12'd200;

    // Half-width is SCALE_MUL times the Q8.8 scale
    localparam logic [6:0] SCALE_MUL = 7'd100;

    typedef struct packed {
        logic signed [15:0] cen_x;
        logic signed [15:0] cen_y;
        logic signed [15:0] cen_z;
        logic [15:0]        scl_x;
        logic [15:0]        scl_y;
        logic [15:0]        scl_z;
        logic [4:0]         region;
    } t_box;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_point;

endpackage

// ===== rtl/zbv_box_mem.sv =====
// ---------------------------------------------------------------------------
// zbv_box_mem
// Box table storage: one write port, one registered read port.
// ---------------------------------------------------------------------------
module zbv_box_mem #(
    parameter int DEPTH = zbv_pkg::MAX_BOXES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  zbv_pkg::t_box i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output zbv_pkg::t_box o_rd_data
);

    zbv_pkg::t_box r_mem [DEPTH];
    zbv_pkg::t_box r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/zbv_box_test.sv =====
// ---------------------------------------------------------------------------
// zbv_box_test
// Shared containment unit: tests one box against a point on all three axes.
// ---------------------------------------------------------------------------
module zbv_box_test (
    input  zbv_pkg::t_box   i_box,
    input  zbv_pkg::t_point i_pt,
    input  logic [11:0]     i_reach,
    output logic [31:0]     o_hit_mask
);

    // Outside when |c - p| * 256 > 100 * s + reach * 256
    function automatic logic axis_out(input logic signed [15:0] c,
                                      input logic signed [15:0] p,
                                      input logic [15:0] s,
                                      input logic [11:0] reach);
        logic signed [16:0] d;
        logic [15:0]        ad;
        logic [23:0]        lhs;
        logic [23:0]        rhs;
        d   = 17'(c) - 17'(p);
        ad  = d[16] ? 16'(-d) : d[15:0];
        lhs = {ad, 8'd0};
        rhs = 24'(s) * 24'(zbv_pkg::SCALE_MUL) + {4'd0, reach, 8'd0};
        return lhs > rhs;
    endfunction

    logic held;

    always_comb begin
        held = !axis_out(i_box.cen_x, i_pt.x, i_box.scl_x, i_reach)
            && !axis_out(i_box.cen_y, i_pt.y, i_box.scl_y, i_reach)
            && !axis_out(i_box.cen_z, i_pt.z, i_box.scl_z, i_reach);
        o_hit_mask = held ? (32'd1 << i_box.region) : 32'd0;
    end

endmodule

// ===== rtl/zone_box_visibility_table.sv =====
// ---------------------------------------------------------------------------
// zone_box_visibility_table
// Axis-aligned box table with viewer update, object classify and mask query.
// ---------------------------------------------------------------------------
// Clear, add and query register their result on the accepting edge. Update
// and classify walk the stored boxes through one shared box tester, one box
// per cycle from the single read port of the box memory, and then hand off
// the result; the slave side is not ready during the walk. A new
// transaction is taken while the previous result is being handed off. There
// is no clearing pass after reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module zone_box_visibility_table #(
    parameter int MAX_BOXES = zbv_pkg::MAX_BOXES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Slave stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z, [63:48] scale_x,
    // [79:64] scale_y, [95:80] scale_z, [100:96] region, [101] door_open,
    // [133:102] query_mask, [134] query_always, [135] zero
    input  logic [135:0] i_s_tdata,
    // [2:0] req_type
    input  logic [2:0]   i_s_tuser,
    // Master stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] visible_regions, [63:32] object_regions, [64] is_visible,
    // [65] status, [71:66] zero
    output logic [71:0]  o_m_tdata,
    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_BOXES);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    // Registers
    logic           r_state,      n_state;
    logic [CW-1:0]  r_box_count,  n_box_count;
    logic [31:0]    r_visible,    n_visible;
    logic [11:0]    r_door_reach, n_door_reach;
    logic [11:0]    r_obj_margin, n_obj_margin;
    logic           r_out_valid,  n_out_valid;
    logic [CW-1:0]  r_idx,        n_idx;
    logic           r_rd_vld,     n_rd_vld;
    logic [31:0]    r_acc,        n_acc;
    logic [31:0]    r_out_vis,    n_out_vis;
    logic [31:0]    r_out_obj,    n_out_obj;
    logic           r_out_isvis,  n_out_isvis;
    logic           r_out_status, n_out_status;
    zbv_pkg::t_point r_pt,        n_pt;
    logic [11:0]    r_reach,      n_reach;
    logic           r_is_update,  n_is_update;
    logic           r_door,       n_door;

    // Input fields
    logic [2:0]      req_type;
    zbv_pkg::t_point in_pt;
    zbv_pkg::t_box   in_box;
    logic            door_open;
    logic [31:0]     query_mask;
    logic            query_always;

    assign req_type     = i_s_tuser;
    assign in_pt.x      = i_s_tdata[15:0];
    assign in_pt.y      = i_s_tdata[31:16];
    assign in_pt.z      = i_s_tdata[47:32];
    assign in_box.cen_x = i_s_tdata[15:0];
    assign in_box.cen_y = i_s_tdata[31:16];
    assign in_box.cen_z = i_s_tdata[47:32];
    assign in_box.scl_x = i_s_tdata[63:48];
    assign in_box.scl_y = i_s_tdata[79:64];
    assign in_box.scl_z = i_s_tdata[95:80];
    assign in_box.region = i_s_tdata[100:96];
    assign door_open    = i_s_tdata[101];
    assign query_mask   = i_s_tdata[133:102];
    assign query_always = i_s_tdata[134];

    logic s_accept;
    logic cfg_wr;
    logic mem_wr_en;
    logic mem_rd_en;
    zbv_pkg::t_box rd_box;
    logic [31:0]   hit_mask;

    assign o_s_tready = i_rst_n && (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign mem_wr_en  = s_accept && (req_type == zbv_pkg::REQ_ADD) && (r_box_count < FULL);
    assign mem_rd_en  = (r_state == S_SCAN) && (r_idx != r_box_count);

    zbv_box_mem #(
        .DEPTH (MAX_BOXES),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_box_count[AW-1:0]),
        .i_wr_data (in_box),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_box)
    );

    zbv_box_test u_test (
        .i_box      (rd_box),
        .i_pt       (r_pt),
        .i_reach    (r_reach),
        .o_hit_mask (hit_mask)
    );

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == zbv_pkg::REG_OBJ_MARGIN) ? {20'd0, r_obj_margin}
                                                          : {20'd0, r_door_reach};

    always_comb begin
        n_state      = r_state;
        n_box_count  = r_box_count;
        n_visible    = r_visible;
        n_door_reach = r_door_reach;
        n_obj_margin = r_obj_margin;
        n_out_valid  = r_out_valid;
        n_idx        = r_idx;
        n_rd_vld     = 1'b0;
        n_acc        = r_acc;
        n_out_vis    = r_out_vis;
        n_out_obj    = r_out_obj;
        n_out_isvis  = r_out_isvis;
        n_out_status = r_out_status;
        n_pt         = r_pt;
        n_reach      = r_reach;
        n_is_update  = r_is_update;
        n_door       = r_door;

        if (cfg_wr) begin
            if (paddr[2] == zbv_pkg::REG_DOOR_REACH) begin
                n_door_reach = pwdata[11:0];
            end else begin
                n_obj_margin = pwdata[11:0];
            end
        end

        // Drop the result once taken
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        if (s_accept) begin
            n_out_vis    = r_visible;
            n_out_obj    = 32'd0;
            n_out_isvis  = 1'b0;
            n_out_status = 1'b0;
            n_out_valid  = 1'b1;
            n_pt         = in_pt;
            n_idx        = '0;
            n_acc        = 32'd0;
            n_door       = door_open;
            unique case (req_type)
                zbv_pkg::REQ_CLEAR: begin
                    n_box_count = '0;
                end
                zbv_pkg::REQ_ADD: begin
                    if (r_box_count < FULL) begin
                        n_box_count = r_box_count + CW'(1);
                    end else begin
                        n_out_status = 1'b1;
                    end
                end
                zbv_pkg::REQ_UPDATE: begin
                    n_out_valid = 1'b0;
                    n_state     = S_SCAN;
                    n_is_update = 1'b1;
                    n_reach     = door_open ? r_door_reach : 12'd0;
                end
                zbv_pkg::REQ_CLASSIFY: begin
                    n_out_valid = 1'b0;
                    n_state     = S_SCAN;
                    n_is_update = 1'b0;
                    n_reach     = r_obj_margin;
                end
                zbv_pkg::REQ_QUERY: begin
                    n_out_isvis = query_always || ((query_mask & r_visible) != 32'd0);
                end
                default: begin
                end
            endcase
        end

        if (r_state == S_SCAN) begin
            if (mem_rd_en) begin
                n_idx    = r_idx + CW'(1);
                n_rd_vld = 1'b1;
            end
            if (r_rd_vld) begin
                n_acc = r_acc | hit_mask;
            end
            if (!mem_rd_en && !r_rd_vld) begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                if (r_is_update) begin
                    n_visible = (r_door ? r_visible : 32'd0) | r_acc;
                    n_out_vis = n_visible;
                    n_out_obj = 32'd0;
                end else begin
                    n_out_vis = r_visible;
                    n_out_obj = r_acc;
                end
                n_out_isvis  = 1'b0;
                n_out_status = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_box_count  <= '0;
            r_visible    <= 32'd0;
            r_door_reach <= zbv_pkg::DOOR_REACH_RST;
            r_obj_margin <= zbv_pkg::OBJ_MARGIN_RST;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            r_rd_vld     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_box_count  <= n_box_count;
            r_visible    <= n_visible;
            r_door_reach <= n_door_reach;
            r_obj_margin <= n_obj_margin;
            r_out_valid  <= n_out_valid;
            r_idx        <= n_idx;
            r_rd_vld     <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc        <= n_acc;
        r_out_vis    <= n_out_vis;
        r_out_obj    <= n_out_obj;
        r_out_isvis  <= n_out_isvis;
        r_out_status <= n_out_status;
        r_pt         <= n_pt;
        r_reach      <= n_reach;
        r_is_update  <= n_is_update;
        r_door       <= n_door;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_status, r_out_isvis, r_out_obj, r_out_vis};

    `ASSERT_ALWAYS(a_count_bound, r_box_count <= FULL, "box count beyond table size")
    `ASSERT_IMPLY(a_scan_blocks_in, r_state == S_SCAN, !o_s_tready && !r_out_valid, "scan overlaps a transaction")
    `ASSERT_IMPLY(a_rd_in_scan, r_rd_vld, r_state == S_SCAN, "read data outside scan")
    `ASSERT_NEXT(a_scan_start, s_accept && (req_type == zbv_pkg::REQ_UPDATE || req_type == zbv_pkg::REQ_CLASSIFY), r_state == S_SCAN && r_idx == '0, "scan did not start")

endmodule
